[rtl/core/segregated_size_class_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Segregated size-class allocator assertion macros
// Shared concurrent-assertion forms used by the allocator's RTL.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_SIZE_CLASS_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_SIZE_CLASS_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SSCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

[rtl/core/ssca_pkg.sv]
// ----------------------------------------------------------------------------
// Segregated size-class allocator package
// Widths, codes, register indexes and shared structures of the allocator.
// ----------------------------------------------------------------------------
package ssca_pkg;

   // Field and register widths.
   localparam int ADDR_W      = 32;
   localparam int REQ_W       = 32;
   localparam int CLASS_W     = 5;
   localparam int COUNT_W     = 13;
   localparam int MCL_W       = 4;
   localparam int LOG2_W      = 5;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // Fixed sizing.
   localparam int HEADER_BYTES     = 16;
   localparam int NUM_CLASSES_DEF  = 8;
   localparam logic [COUNT_W-1:0] BLOCKS_MAX = '1;

   // Register reset values.
   localparam logic [MCL_W-1:0]  MIN_CLASS_LOG2_RST = 4'd5;
   localparam logic [LOG2_W-1:0] PAGE_LOG2_RST      = 5'd12;
   localparam logic [ADDR_W-1:0] HEAP_BASE_RST      = '0;
   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST     = '1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CLASS_LOG2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_LOG2      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT     = 3'd3;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_OOM       = 2'd2
   } status_type;

   // One class entry as held in the class memory.
   typedef struct packed {
      logic [ADDR_W-1:0]  next_addr;
      logic [COUNT_W-1:0] blocks_left;
   } class_entry_type;

   // Outcome of the size-class search.
   typedef struct packed {
      logic               too_large;
      logic [CLASS_W-1:0] cls;
      logic [LOG2_W-1:0]  blk_log2;
   } class_pick_type;

   // Outcome of sizing a fresh chunk from the break pointer.
   typedef struct packed {
      logic [ADDR_W:0]    chunk;
      logic [COUNT_W-1:0] nblk;
      logic               oom;
   } carve_type;

endpackage

[rtl/core/ssca_class_sel.sv]
// ----------------------------------------------------------------------------
// Size-class selector
// Picks the smallest power-of-two class whose block holds request plus header.
// ----------------------------------------------------------------------------
module ssca_class_sel #(
   parameter int NUM_CLASSES = ssca_pkg::NUM_CLASSES_DEF
) (
   input  logic [ssca_pkg::REQ_W-1:0] request_bytes,
   input  logic [ssca_pkg::MCL_W-1:0] min_class_log2,
   output ssca_pkg::class_pick_type   pick
);

   localparam int NEED_W = ssca_pkg::REQ_W + 1;

   logic [NEED_W-1:0]          need_m1;
   logic [ssca_pkg::LOG2_W-1:0] exp_k [NUM_CLASSES];
   logic [NUM_CLASSES-1:0]     fits;

   // A block of 2^e bytes holds need bytes when (need - 1) >> e is zero.
   assign need_m1 = NEED_W'(request_bytes) + NEED_W'(ssca_pkg::HEADER_BYTES - 1);

   // Each class is tested on its own.
   always_comb begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
         exp_k[k] = ssca_pkg::LOG2_W'(min_class_log2) + ssca_pkg::LOG2_W'(k);
         fits[k]  = (need_m1 >> exp_k[k]) == '0;
      end
   end

   // The lowest fitting class wins.
   always_comb begin
      pick.too_large = 1'b1;
      pick.cls       = ssca_pkg::CLASS_W'(NUM_CLASSES);
      pick.blk_log2  = '0;
      for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
         if (fits[k]) begin
            pick.too_large = 1'b0;
            pick.cls       = ssca_pkg::CLASS_W'(k);
            pick.blk_log2  = exp_k[k];
         end
      end
   end

endmodule

[rtl/core/ssca_carve.sv]
// ----------------------------------------------------------------------------
// Chunk carver
// Sizes a fresh chunk for an empty class and checks it against the heap limit.
// ----------------------------------------------------------------------------
module ssca_carve (
   input  logic [ssca_pkg::LOG2_W-1:0] blk_log2,
   input  logic [ssca_pkg::LOG2_W-1:0] page_log2,
   input  logic [ssca_pkg::ADDR_W-1:0] break_addr,
   input  logic [ssca_pkg::ADDR_W-1:0] heap_limit,
   output ssca_pkg::carve_type         carve
);

   localparam int CHUNK_W = ssca_pkg::ADDR_W + 1;
   localparam int END_W   = CHUNK_W + 1;

   logic [CHUNK_W-1:0]           page_sz;
   logic [CHUNK_W-1:0]           blk_sz;
   logic                         blk_ge_page;
   logic [ssca_pkg::LOG2_W-1:0]  log2_diff;
   logic [ssca_pkg::COUNT_W-1:0] nblk;
   logic [END_W-1:0]             end_addr;

   // Chunk is one page, plus the block itself when it spans whole pages.
   assign page_sz     = CHUNK_W'(1) << page_log2;
   assign blk_sz      = CHUNK_W'(1) << blk_log2;
   assign blk_ge_page = blk_log2 >= page_log2;
   assign carve.chunk = page_sz + (blk_ge_page ? blk_sz : '0);

   // Blocks per chunk: two when block equals page, one when larger,
   // otherwise page / block saturated at the counter's limit.
   assign log2_diff = page_log2 - blk_log2;

   always_comb begin
      if (blk_ge_page) begin
         nblk = (blk_log2 == page_log2) ? ssca_pkg::COUNT_W'(2)
                                        : ssca_pkg::COUNT_W'(1);
      end else if (log2_diff >= ssca_pkg::LOG2_W'(ssca_pkg::COUNT_W)) begin
         nblk = ssca_pkg::BLOCKS_MAX;
      end else begin
         nblk = ssca_pkg::COUNT_W'(1) << log2_diff;
      end
   end

   assign carve.nblk = nblk;

   // The new break may not pass the heap limit.
   assign end_addr  = END_W'(break_addr) + END_W'(carve.chunk);
   assign carve.oom = end_addr > END_W'(heap_limit);

endmodule

[rtl/core/ssca_class_mem.sv]
// ----------------------------------------------------------------------------
// Class table memory
// Synchronous class-entry store with registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module ssca_class_mem #(
   parameter  int NUM_CLASSES = ssca_pkg::NUM_CLASSES_DEF,
   localparam int AW          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output ssca_pkg::class_entry_type rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  ssca_pkg::class_entry_type wr_data
);

   ssca_pkg::class_entry_type mem [NUM_CLASSES];
   ssca_pkg::class_entry_type rd_q_ff;
   logic [NUM_CLASSES-1:0]    valid_ff;
   logic                      rd_valid_ff;

   // Storage array and its read register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // Entries never written read as an empty class.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

[rtl/core/segregated_size_class_allocator.sv]
// ----------------------------------------------------------------------------
// Segregated size-class allocator
// Quick-fit style allocator with per-class bump pointers and a carving break.
// ----------------------------------------------------------------------------
// Each request passes through ST_IDLE and then ST_CALC: in ST_IDLE it is
// accepted, its size class is chosen and its entry is read from the class
// memory; in ST_CALC the entry is updated, a chunk is carved from the break
// pointer when the class is empty, the entry is written back on success and
// the result is registered. ST_CALC waits while an earlier result is held on
// the response side. The class memory read is registered; one request is in
// flight at a time, and the next request is accepted once the current one
// has left ST_CALC, even if its result is still waiting on the response side.
// Class entries come out of reset empty through valid bits, so no clearing
// pass is needed. Writing heap_base also reloads the break pointer.
// ----------------------------------------------------------------------------
`include "segregated_size_class_allocator_defines.svh"

module segregated_size_class_allocator #(
   parameter int NUM_CLASSES = ssca_pkg::NUM_CLASSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ssca_pkg::REQ_W-1:0]      req_request_bytes,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssca_pkg::ADDR_W-1:0]     rsp_data_address,
   output logic [ssca_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ssca_pkg::CLASS_W-1:0]    rsp_size_class,
   // Configuration write port.
   input  logic                            csr_wr_en,
   input  logic [ssca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssca_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   state_type                     state_ff;
   logic [ssca_pkg::MCL_W-1:0]    min_class_log2_ff;
   logic [ssca_pkg::LOG2_W-1:0]   page_log2_ff;
   logic [ssca_pkg::ADDR_W-1:0]   heap_limit_ff;
   logic [ssca_pkg::ADDR_W-1:0]   break_ff;
   logic [ssca_pkg::ADDR_W-1:0]   break_in;
   ssca_pkg::class_pick_type      pick;
   ssca_pkg::class_pick_type      pick_ff;
   ssca_pkg::class_entry_type     entry_rd;
   ssca_pkg::class_entry_type     entry_in;
   ssca_pkg::carve_type           carve;
   logic                          rsp_valid_ff;
   logic [ssca_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [ssca_pkg::ADDR_W-1:0]   rsp_addr_in;
   ssca_pkg::status_type          rsp_status_ff;
   ssca_pkg::status_type          rsp_status_in;
   logic [ssca_pkg::CLASS_W-1:0]  rsp_class_ff;
   logic                          accept;
   logic                          calc_fire;
   logic                          class_empty;
   logic                          alloc_ok;
   logic                          take_break;
   logic [ssca_pkg::ADDR_W-1:0]   blk_sz;
   logic [ssca_pkg::ADDR_W-1:0]   blk_base;
   logic [ssca_pkg::COUNT_W-1:0]  blk_count;

   // Handshake qualifiers.
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign calc_fire = (state_ff == ST_CALC) && (!rsp_valid_ff || rsp_ready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_class_log2_ff <= ssca_pkg::MIN_CLASS_LOG2_RST;
         page_log2_ff      <= ssca_pkg::PAGE_LOG2_RST;
         heap_limit_ff     <= ssca_pkg::HEAP_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            ssca_pkg::CSR_MIN_CLASS_LOG2: begin
               min_class_log2_ff <= csr_wdata[ssca_pkg::MCL_W-1:0];
            end
            ssca_pkg::CSR_PAGE_LOG2: begin
               page_log2_ff <= csr_wdata[ssca_pkg::LOG2_W-1:0];
            end
            ssca_pkg::CSR_HEAP_LIMIT: begin
               heap_limit_ff <= csr_wdata[ssca_pkg::ADDR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Size-class search on the incoming request.
   ssca_class_sel #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_class_sel (
      .request_bytes  (req_request_bytes),
      .min_class_log2 (min_class_log2_ff),
      .pick           (pick)
   );

   // Class entries: read at acceptance, written back when a request completes successfully.
   ssca_class_mem #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_class_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pick.cls[AW-1:0]),
      .rd_data (entry_rd),
      .wr_en   (calc_fire && alloc_ok),
      .wr_addr (pick_ff.cls[AW-1:0]),
      .wr_data (entry_in)
   );

   // Chunk sizing for an empty class.
   ssca_carve u_carve (
      .blk_log2   (pick_ff.blk_log2),
      .page_log2  (page_log2_ff),
      .break_addr (break_ff),
      .heap_limit (heap_limit_ff),
      .carve      (carve)
   );

   // Allocation from the chosen class, carving first when it is empty.
   assign class_empty = entry_rd.blocks_left == '0;
   assign alloc_ok    = !pick_ff.too_large && !(class_empty && carve.oom);
   assign take_break  = alloc_ok && class_empty;
   assign blk_sz      = ssca_pkg::ADDR_W'(1) << pick_ff.blk_log2;
   assign blk_base    = class_empty ? break_ff : entry_rd.next_addr;
   assign blk_count   = class_empty ? carve.nblk : entry_rd.blocks_left;

   assign entry_in.next_addr   = blk_base + blk_sz;
   assign entry_in.blocks_left = blk_count - ssca_pkg::COUNT_W'(1);
   assign break_in             = break_ff + carve.chunk[ssca_pkg::ADDR_W-1:0];

   // Result fields.
   always_comb begin
      rsp_addr_in = '0;
      if (pick_ff.too_large) begin
         rsp_status_in = ssca_pkg::STATUS_TOO_LARGE;
      end else if (!alloc_ok) begin
         rsp_status_in = ssca_pkg::STATUS_OOM;
      end else begin
         rsp_status_in = ssca_pkg::STATUS_OK;
         rsp_addr_in   = blk_base + ssca_pkg::ADDR_W'(ssca_pkg::HEADER_BYTES);
      end
   end

   // Sequencer, break pointer and registered response.
   always_ff @(posedge clock) begin
      if (accept) begin
         pick_ff <= pick;
      end
      if (calc_fire) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
         rsp_class_ff  <= pick_ff.cls;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         break_ff     <= ssca_pkg::HEAP_BASE_RST;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (calc_fire) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (calc_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr_en && (csr_index == ssca_pkg::CSR_HEAP_BASE)) begin
            break_ff <= csr_wdata[ssca_pkg::ADDR_W-1:0];
         end else if (calc_fire && take_break) begin
            break_ff <= break_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_size_class   = rsp_class_ff;

   // Failed requests never carry an address.
   `SSCA_ASSERT_IMPL(a_err_addr_zero, clock, reset, rsp_valid && (rsp_status != ssca_pkg::STATUS_OK), rsp_data_address == '0)

   // A successful request always names a real class.
   `SSCA_ASSERT_IMPL(a_ok_class_range, clock, reset, rsp_valid && (rsp_status == ssca_pkg::STATUS_OK), rsp_size_class < ssca_pkg::CLASS_W'(NUM_CLASSES))

   // Only one request is in flight: acceptance closes the request side.
   `SSCA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // A fresh response follows an accepted request.
   `SSCA_ASSERT_IMPL(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Segregated size-class allocator testbench
// Sends allocation requests over the request channel and checks every result
// against a cycle-free prediction of class choice, carving, out-of-memory and
// oversize handling. A short directed part covers the corner cases; random
// phases follow, each with fresh register settings and its own idling mix.
// ----------------------------------------------------------------------------

// One expected allocation result.
typedef struct {
   logic [ssca_pkg::ADDR_W-1:0]  data_address;
   ssca_pkg::status_type         status;
   logic [ssca_pkg::CLASS_W-1:0] size_class;
} alloc_grant_type;

// Predicts allocator results and checks what the block returns.
class allocator_scoreboard;
   localparam int REPORT_LINES = 40;

   logic [ssca_pkg::MCL_W-1:0]   min_class_log2;
   logic [ssca_pkg::LOG2_W-1:0]  page_log2;
   logic [ssca_pkg::ADDR_W-1:0]  heap_base;
   logic [ssca_pkg::ADDR_W-1:0]  heap_limit;
   logic [ssca_pkg::ADDR_W-1:0]  next_addr [ssca_pkg::NUM_CLASSES_DEF];
   logic [ssca_pkg::COUNT_W-1:0] blocks_left [ssca_pkg::NUM_CLASSES_DEF];
   logic [ssca_pkg::ADDR_W-1:0]  break_addr;
   alloc_grant_type              grants [$];
   int                           errors;

   function new();
      min_class_log2 = ssca_pkg::MIN_CLASS_LOG2_RST;
      page_log2 = ssca_pkg::PAGE_LOG2_RST;
      heap_base = ssca_pkg::HEAP_BASE_RST;
      heap_limit = ssca_pkg::HEAP_LIMIT_RST;
      break_addr = ssca_pkg::HEAP_BASE_RST;
      for (int k = 0; k < ssca_pkg::NUM_CLASSES_DEF; k++) begin
         next_addr[k] = '0;
         blocks_left[k] = '0;
      end
      errors = 0;
   endfunction

   // A heap_base write also moves the break; class lists stay as they are.
   function void write_register(logic [ssca_pkg::CSR_IDX_W-1:0] index,
                                logic [ssca_pkg::CSR_DATA_W-1:0] value);
      case (index)
         ssca_pkg::CSR_MIN_CLASS_LOG2: min_class_log2 = value[ssca_pkg::MCL_W-1:0];
         ssca_pkg::CSR_PAGE_LOG2: page_log2 = value[ssca_pkg::LOG2_W-1:0];
         ssca_pkg::CSR_HEAP_BASE: begin
            heap_base = value;
            break_addr = value;
         end
         ssca_pkg::CSR_HEAP_LIMIT: heap_limit = value;
         default: ;
      endcase
   endfunction

   function int outstanding();
      return grants.size();
   endfunction

   // Works out the result of one accepted request and updates the class state.
   function void note_request(logic [ssca_pkg::REQ_W-1:0] nbytes);
      logic [63:0]     need;
      logic [63:0]     blk_bytes;
      logic [63:0]     page;
      logic [63:0]     chunk;
      logic [63:0]     blocks;
      int              cls;
      alloc_grant_type grant;
      need = 64'(nbytes) + 64'(ssca_pkg::HEADER_BYTES);
      blk_bytes = '0;
      cls = ssca_pkg::NUM_CLASSES_DEF;
      // Scan downward so the smallest fitting class wins.
      for (int k = ssca_pkg::NUM_CLASSES_DEF - 1; k >= 0; k--) begin
         if (need <= (64'd1 << (int'(min_class_log2) + k))) begin
            cls = k;
            blk_bytes = 64'd1 << (int'(min_class_log2) + k);
         end
      end
      grant.data_address = '0;
      grant.size_class = ssca_pkg::CLASS_W'(cls);
      if (cls == ssca_pkg::NUM_CLASSES_DEF) begin
         grant.status = ssca_pkg::STATUS_TOO_LARGE;
      end else begin
         grant.status = ssca_pkg::STATUS_OK;
         // An empty class carves one page plus whole pages covering the block.
         if (blocks_left[cls] == '0) begin
            page = 64'd1 << page_log2;
            chunk = page + (blk_bytes / page) * page;
            blocks = chunk / blk_bytes;
            if (64'(break_addr) + chunk > 64'(heap_limit)) begin
               grant.status = ssca_pkg::STATUS_OOM;
            end else begin
               next_addr[cls] = break_addr;
               blocks_left[cls] = (blocks > 64'(ssca_pkg::BLOCKS_MAX))
                                  ? ssca_pkg::BLOCKS_MAX
                                  : blocks[ssca_pkg::COUNT_W-1:0];
               break_addr = ssca_pkg::ADDR_W'(64'(break_addr) + chunk);
            end
         end
         if (grant.status == ssca_pkg::STATUS_OK) begin
            grant.data_address = next_addr[cls]
                                 + ssca_pkg::ADDR_W'(ssca_pkg::HEADER_BYTES);
            next_addr[cls] = next_addr[cls] + ssca_pkg::ADDR_W'(blk_bytes);
            blocks_left[cls] = blocks_left[cls] - 1'b1;
         end
      end
      grants.push_back(grant);
   endfunction

   task report(string what);
      errors++;
      if (errors <= REPORT_LINES) $display("mismatch at %0t: %s", $time, what);
   endtask

   // Compares one accepted result with the oldest expected one.
   task check_result(logic [ssca_pkg::ADDR_W-1:0] addr,
                     logic [ssca_pkg::STATUS_W-1:0] status,
                     logic [ssca_pkg::CLASS_W-1:0] size_class);
      alloc_grant_type grant;
      if (grants.size() == 0) begin
         report($sformatf("unexpected result address %h status %0d class %0d",
                          addr, status, size_class));
         return;
      end
      grant = grants.pop_front();
      if (addr !== grant.data_address)
         report($sformatf("data_address %h, expected %h", addr, grant.data_address));
      if (status !== grant.status)
         report($sformatf("status %0d, expected %0d", status, grant.status));
      if (size_class !== grant.size_class)
         report($sformatf("size_class %0d, expected %0d", size_class, grant.size_class));
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 6;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 112;
   localparam logic [ssca_pkg::CSR_IDX_W-1:0] STRAY_INDEX_LOW =
      ssca_pkg::CSR_HEAP_LIMIT + 1'b1;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [ssca_pkg::REQ_W-1:0]      req_request_bytes = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [ssca_pkg::ADDR_W-1:0]     rsp_data_address;
   logic [ssca_pkg::STATUS_W-1:0]   rsp_status;
   logic [ssca_pkg::CLASS_W-1:0]    rsp_size_class;
   logic                            csr_wr_en = 1'b0;
   logic [ssca_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ssca_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int send_idle_pattern [4] = '{0, 69, 0, 15};
   int stall_pattern [4] = '{0, 0, 69, 15};

   allocator_scoreboard board = new();

   segregated_size_class_allocator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_request_bytes(req_request_bytes),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data_address(rsp_data_address),
      .rsp_status(rsp_status),
      .rsp_size_class(rsp_size_class),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The receiver stalls at random with the current percentage.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Both handshakes are sampled at the edge that completes them.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_data_address, rsp_status, rsp_size_class);
         if (req_valid && req_ready)
            board.note_request(req_request_bytes);
      end
   end

   // Offers one request after a random gap and returns once it is accepted.
   task automatic send_request(input logic [ssca_pkg::REQ_W-1:0] nbytes);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_request_bytes <= nbytes;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ssca_pkg::CSR_IDX_W-1:0] index,
                            input logic [ssca_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   // Reprograms the registers once the block is idle.
   task automatic set_registers(input logic [ssca_pkg::CSR_DATA_W-1:0] mcl_word,
                                input logic [ssca_pkg::CSR_DATA_W-1:0] page_word,
                                input logic [ssca_pkg::CSR_DATA_W-1:0] base,
                                input logic [ssca_pkg::CSR_DATA_W-1:0] limit,
                                input bit write_base, input bit stray_write);
      wait_drained();
      write_csr(ssca_pkg::CSR_MIN_CLASS_LOG2, mcl_word);
      write_csr(ssca_pkg::CSR_PAGE_LOG2, page_word);
      if (write_base) write_csr(ssca_pkg::CSR_HEAP_BASE, base);
      write_csr(ssca_pkg::CSR_HEAP_LIMIT, limit);
      if (stray_write)
         write_csr(ssca_pkg::CSR_IDX_W'($urandom_range(int'(STRAY_INDEX_LOW), 7)),
                   $urandom());
      csr_wr_en <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   task automatic run_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      // Reset settings: class boundaries, oversize requests, a need beyond 32 bits.
      send_request(32'd0);
      send_request(32'd16);
      send_request(32'd17);
      send_request(32'd4080);
      send_request(32'd4081);
      send_request(32'hFFFF_FFFF);
      send_request(32'hFFFF_FFF0);
      send_request(32'd100);
      // Small heap: earlier class lists serve most requests; only the 100-byte one carves.
      set_registers(32'd4, 32'd12, 32'h0000_1000, 32'h0000_3000, 1'b1, 1'b1);
      send_request(32'd0);
      send_request(32'd2032);
      send_request(32'd100);
      send_request(32'd0);
      // Blocks larger than a page take extra whole pages per chunk.
      set_registers(32'd8, 32'd12, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'd32000);
      send_request(32'd32000);
      // Huge pages with tiny blocks; both requests are served from the earlier class-0 list.
      set_registers(32'd4, 32'd20, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_request(32'd0);
      send_request(32'd0);
      // Widest settings with junk above the register fields.
      set_registers(32'hABCD_123F, 32'h5A5A_5A5F, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'd0);
      send_request(32'd40000);
      send_request(32'd0);
      // Single-byte pages near the top of the address space.
      set_registers(32'd5, 32'd0, 32'hFFFF_E000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'd0);
      send_request(32'd4080);
      // A zero limit leaves no room for carving; the request is served from the earlier class-0 list.
      set_registers(32'd5, 32'd12, 32'h0, 32'h0, 1'b1, 1'b0);
      send_request(32'd0);
      // The break starts one page below the last address; both requests are served from earlier class lists.
      set_registers(32'd5, 32'd12, 32'hFFFF_EFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_request(32'd0);
      send_request(32'd20);
   endtask

   // One random phase: new registers, then mostly fitting requests.
   task automatic run_random_phase(input int items, input int idle_pct, input int stall);
      logic [ssca_pkg::CSR_DATA_W-1:0] mcl_word;
      logic [ssca_pkg::CSR_DATA_W-1:0] page_word;
      logic [ssca_pkg::CSR_DATA_W-1:0] base;
      logic [ssca_pkg::CSR_DATA_W-1:0] limit;
      logic [ssca_pkg::REQ_W-1:0]      nbytes;
      longint                          span;
      longint                          hi;
      longint                          lo;
      int                              k;
      int                              sel;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      mcl_word = (($urandom_range(0, 99) < 80) ? $urandom_range(4, 8) : $urandom_range(0, 15));
      mcl_word = mcl_word | ($urandom() & ~32'hF);
      page_word = (($urandom_range(0, 99) < 80) ? $urandom_range(12, 16)
                                                : $urandom_range(0, 31));
      page_word = page_word | ($urandom() & ~32'h1F);
      sel = $urandom_range(0, 99);
      base = (sel < 50) ? ($urandom() & ~32'hFFF) : ((sel < 80) ? $urandom() : 32'h0);
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         limit = 32'hFFFF_FFFF;
      end else if (sel < 70) begin
         span = longint'(base) + longint'($urandom_range(1, 40)) * 4096;
         limit = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      end else begin
         limit = $urandom();
      end
      set_registers(mcl_word, page_word, base, limit, $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) == 0);
      for (int i = 0; i < items; i++) begin
         // Midway the sender holds off until the block has answered everything.
         if (i == items / 2) wait_drained();
         sel = $urandom_range(0, 99);
         k = $urandom_range(0, ssca_pkg::NUM_CLASSES_DEF - 1);
         hi = (longint'(1) << (int'(board.min_class_log2) + k)) - ssca_pkg::HEADER_BYTES;
         lo = (k == 0) ? 0 : (longint'(1) << (int'(board.min_class_log2) + k - 1))
                            - ssca_pkg::HEADER_BYTES + 1;
         if (lo < 0) lo = 0;
         if (sel < 8) begin
            nbytes = $urandom();
         end else if (hi < 0) begin
            nbytes = $urandom_range(0, 15);
         end else if (sel < 16) begin
            // Exactly filling a class, or one byte past it.
            nbytes = ssca_pkg::REQ_W'(hi + $urandom_range(0, 1));
         end else begin
            nbytes = $urandom_range(ssca_pkg::REQ_W'(hi), ssca_pkg::REQ_W'(lo));
         end
         send_request(nbytes);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < PHASES; p++)
         run_random_phase(PHASE_ITEMS, send_idle_pattern[p % 4], stall_pattern[p % 4]);
      wait_drained();
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/ssca_pkg.sv
rtl/core/ssca_class_sel.sv
rtl/core/ssca_carve.sv
rtl/core/ssca_class_mem.sv
rtl/core/segregated_size_class_allocator.sv
tb/testbench.sv
